FILE: design/shd_pkg.sv
package shd_pkg;

  // Seed geometry
  localparam int SEED_BITS     = 440;
  localparam int SEED_BYTES    = SEED_BITS / 8;
  localparam int MAX_OUT_BYTES = 32;
  localparam int IDX_W         = 6;

  // SM3 constants
  localparam logic [255:0] SM3_IV =
    256'h7380166f4914b2b9172442d7da8a0600a96f30bc163138aae38dee4db0fb0e4e;
  localparam logic [31:0] SM3_T_LO = 32'h79cc4519;
  localparam logic [31:0] SM3_T_HI = 32'h7a879d8a;

  // Prefix and padding bytes
  localparam logic [7:0] BYTE_DERIVE_C = 8'h00;
  localparam logic [7:0] BYTE_RESEED   = 8'h01;
  localparam logic [7:0] BYTE_GEN      = 8'h02;
  localparam logic [7:0] BYTE_UPDATE   = 8'h03;
  localparam logic [7:0] BYTE_PAD      = 8'h80;
  localparam logic [7:0] BYTE_ZERO     = 8'h00;
  localparam logic [5:0] PAD_END       = 6'd56;

  // Context masks
  localparam logic [1:0] MASK_DF = 2'b11;
  localparam logic [1:0] MASK_H0 = 2'b01;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SECONDS = 2'd1;

  typedef enum logic [1:0] {
    KIND_INST, KIND_RESEED, KIND_GEN, KIND_TICK
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE, PH_INST, PH_RS_PRE, PH_RS_POST,
    PH_GD_PRE, PH_GD_POST, PH_GP_NONE, PH_GP_SEEN
  } phase_e;

  typedef enum logic [2:0] {
    SRC_IN, SRC_CONST, SRC_HDR, SRC_V, SRC_LEN
  } src_e;

  typedef enum logic [1:0] {
    ADD_TMP, ADD_C, ADD_CNT
  } add_e;

  typedef enum logic [4:0] {
    ST_WAIT, ST_START, ST_HDR, ST_ONE, ST_TWO, ST_VB, ST_BYTE, ST_INB,
    ST_LAST, ST_DFIN, ST_STV, ST_ZERO, ST_CFIN, ST_STC, ST_ADDT, ST_G1,
    ST_G1F, ST_G1D, ST_THREE, ST_G2F, ST_ADD2, ST_ADDC, ST_ADDN, ST_OUT,
    ST_OSEND, ST_ERR, ST_PAD80, ST_PAD0, ST_PADL
  } ctrl_state_e;

  typedef struct packed {
    logic             init;
    logic             feed;
    logic [1:0]       mask;
    src_e             src;
    logic [7:0]       cbyte;
    logic [IDX_W-1:0] idx;
    logic             latch_len;
    logic             load_byte;
    logic             store_v;
    logic             store_c;
    logic             store_dig;
    logic             add;
    add_e             add_sel;
    logic             reseed_rst;
    logic             cnt_inc;
    logic             tick;
    logic             out_load;
    logic             out_err;
    logic             out_last;
    logic [1:0]       out_k;
    logic [3:0]       out_vb;
  } dp_cmd_t;

  typedef struct packed {
    logic       busy;
    logic       due;
    logic [5:0] pos;
  } dp_status_t;

endpackage

FILE: design/shd_sm3_core.sv
module shd_sm3_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [511:0] block_i,
  input  logic [255:0] chain_i,
  output logic         busy_o,
  output logic         done_o,
  output logic [255:0] hash_o
);
  import shd_pkg::*;

  function automatic logic [31:0] rol32(input logic [31:0] x, input logic [4:0] n);
    return (x << n) | (x >> (6'd32 - {1'b0, n}));
  endfunction

  function automatic logic [31:0] p0(input logic [31:0] x);
    return x ^ rol32(x, 5'd9) ^ rol32(x, 5'd17);
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] x);
    return x ^ rol32(x, 5'd15) ^ rol32(x, 5'd23);
  endfunction

  logic [31:0]  a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
  logic [31:0]  w_q [16];
  logic [255:0] v_q;
  logic [5:0]   rnd_q;
  logic         run_q, done_q;

  logic        early;
  logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2, wnew;

  // One compression round
  always_comb begin
    early = (rnd_q < 6'd16);
    tj    = early ? SM3_T_LO : SM3_T_HI;
    a12   = rol32(a_q, 5'd12);
    ss1   = rol32(a12 + e_q + rol32(tj, rnd_q[4:0]), 5'd7);
    ss2   = ss1 ^ a12;
    ff    = early ? (a_q ^ b_q ^ c_q) : ((a_q & b_q) | (a_q & c_q) | (b_q & c_q));
    gg    = early ? (e_q ^ f_q ^ g_q) : ((e_q & f_q) | (~e_q & g_q));
    tt1   = ff + d_q + ss2 + (w_q[0] ^ w_q[4]);
    tt2   = gg + h_q + ss1 + w_q[0];
    wnew  = p1(w_q[0] ^ w_q[7] ^ rol32(w_q[13], 5'd15)) ^ rol32(w_q[3], 5'd7) ^ w_q[10];
  end

  // Round control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !run_q) begin
        run_q <= 1'b1;
        rnd_q <= '0;
      end else if (run_q) begin
        rnd_q <= rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Working variables and message window
  always_ff @(posedge clk_i) begin
    if (start_i && !run_q) begin
      {a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q} <= chain_i;
      v_q <= chain_i;
      for (int i = 0; i < 16; i++) begin
        w_q[i] <= block_i[(15 - i) * 32 +: 32];
      end
    end else if (run_q) begin
      d_q <= c_q;
      c_q <= rol32(b_q, 5'd9);
      b_q <= a_q;
      a_q <= tt1;
      h_q <= g_q;
      g_q <= rol32(f_q, 5'd19);
      f_q <= e_q;
      e_q <= p0(tt2);
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i + 1];
      end
      w_q[15] <= wnew;
    end
  end

  assign busy_o = run_q;
  assign done_o = done_q;
  assign hash_o = v_q ^ {a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q};

endmodule

FILE: design/shd_datapath.sv
module shd_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  shd_pkg::dp_cmd_t               cmd_i,
  output shd_pkg::dp_status_t            stat_o,
  input  logic [7:0]                     data_byte_i,
  input  logic                           cfg_valid_i,
  input  logic [shd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  output logic [63:0]                    out_word_o,
  output logic [1:0]                     word_index_o,
  output logic [3:0]                     valid_bytes_o,
  output logic                           res_status_o,
  output logic                           last_word_o
);
  import shd_pkg::*;

  localparam logic [7:0] DF_CTR0 = 8'h01;
  localparam logic [7:0] DF_CTR1 = 8'h02;

  function automatic logic [7:0] hdr_byte(input logic [2:0] i, input logic ctx);
    logic [7:0] r;
    case (i)
      3'd3:    r = ctx ? DF_CTR1 : DF_CTR0;
      3'd6:    r = 8'(SEED_BITS / 256);
      3'd7:    r = 8'(SEED_BITS % 256);
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  logic [SEED_BITS-1:0] v_q, c_q;
  logic [31:0]  cnt_q, sec_q, max_cnt_q, max_sec_q;
  logic [255:0] chain_q [2];
  logic [511:0] buf_q [2];
  logic [63:0]  len_q [2];
  logic [63:0]  bits_q;
  logic [7:0]   byte_q;
  logic [255:0] dig_q;
  logic [1:0]   pend_q;
  logic         sel_q;

  logic [63:0] out_word_q;
  logic [1:0]  word_index_q;
  logic [3:0]  valid_bytes_q;
  logic        res_status_q, last_word_q;

  logic [5:0]   pos [2];
  logic [7:0]   fbyte [2];
  logic [5:0]   vsel;
  logic [7:0]   vbyte;
  logic         core_start, core_busy, core_done, start_sel;
  logic [255:0] core_hash;
  logic [SEED_BITS-1:0] addend;
  logic [3:0]   pad_n;
  logic [63:0]  word_mask;

  // Byte source per context
  always_comb begin
    vsel  = 6'(SEED_BYTES - 1) - cmd_i.idx;
    vbyte = v_q[{vsel, 3'b000} +: 8];
    for (int k = 0; k < 2; k++) begin
      pos[k] = len_q[k][5:0];
      case (cmd_i.src)
        SRC_IN:    fbyte[k] = byte_q;
        SRC_CONST: fbyte[k] = cmd_i.cbyte;
        SRC_HDR:   fbyte[k] = hdr_byte(cmd_i.idx[2:0], k[0]);
        SRC_V:     fbyte[k] = vbyte;
        SRC_LEN:   fbyte[k] = bits_q[{~cmd_i.idx[2:0], 3'b000} +: 8];
        default:   fbyte[k] = 8'h00;
      endcase
    end
  end

  // Full blocks queue for the shared compression unit, context 0 first
  assign start_sel  = !pend_q[0];
  assign core_start = !core_busy && (pend_q != 2'b00);

  shd_sm3_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (core_start),
    .block_i (buf_q[start_sel]),
    .chain_i (chain_q[start_sel]),
    .busy_o  (core_busy),
    .done_o  (core_done),
    .hash_o  (core_hash)
  );

  // Shared 440-bit adder operand
  always_comb begin
    case (cmd_i.add_sel)
      ADD_TMP: addend = {{(SEED_BITS - 256){1'b0}}, chain_q[0]};
      ADD_C:   addend = c_q;
      ADD_CNT: addend = {{(SEED_BITS - 32){1'b0}}, cnt_q};
      default: addend = '0;
    endcase
  end

  // Output byte mask
  always_comb begin
    pad_n     = 4'd8 - cmd_i.out_vb;
    word_mask = {64{1'b1}} << {pad_n[2:0], 3'b000};
  end

  // Control and seed state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= 2'b00;
      v_q       <= '0;
      c_q       <= '0;
      cnt_q     <= '0;
      sec_q     <= '0;
      max_cnt_q <= 32'd1048576;
      max_sec_q <= 32'd600;
    end else begin
      if (core_start) begin
        pend_q[start_sel] <= 1'b0;
      end
      if (cmd_i.feed) begin
        for (int k = 0; k < 2; k++) begin
          if (cmd_i.mask[k] && pos[k] == 6'd63) begin
            pend_q[k] <= 1'b1;
          end
        end
      end
      if (cmd_i.store_v) begin
        v_q <= {chain_q[0], chain_q[1][255 -: (SEED_BITS - 256)]};
      end else if (cmd_i.add) begin
        v_q <= v_q + addend;
      end
      if (cmd_i.store_c) begin
        c_q <= {chain_q[0], chain_q[1][255 -: (SEED_BITS - 256)]};
      end
      if (cmd_i.reseed_rst) begin
        cnt_q <= 32'd1;
        sec_q <= '0;
      end else begin
        if (cmd_i.cnt_inc) begin
          cnt_q <= cnt_q + 32'd1;
        end
        if (cmd_i.tick && sec_q != 32'hffff_ffff) begin
          sec_q <= sec_q + 32'd1;
        end
      end
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_MAX_COUNT) begin
          max_cnt_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_MAX_SECONDS) begin
          max_sec_q <= cfg_data_i;
        end
      end
    end
  end

  // Hash contexts, buffers and result payload
  always_ff @(posedge clk_i) begin
    if (core_start) begin
      sel_q <= start_sel;
    end
    if (core_done) begin
      chain_q[sel_q] <= core_hash;
    end
    if (cmd_i.init) begin
      for (int k = 0; k < 2; k++) begin
        if (cmd_i.mask[k]) begin
          chain_q[k] <= SM3_IV;
          len_q[k]   <= '0;
        end
      end
    end
    if (cmd_i.feed) begin
      for (int k = 0; k < 2; k++) begin
        if (cmd_i.mask[k]) begin
          buf_q[k][{~pos[k], 3'b000} +: 8] <= fbyte[k];
          len_q[k] <= len_q[k] + 64'd1;
        end
      end
    end
    if (cmd_i.latch_len) begin
      bits_q <= {len_q[0][60:0], 3'b000};
    end
    if (cmd_i.load_byte) begin
      byte_q <= data_byte_i;
    end
    if (cmd_i.store_dig) begin
      dig_q <= chain_q[0];
    end
    if (cmd_i.out_load) begin
      if (cmd_i.out_err) begin
        out_word_q    <= '0;
        word_index_q  <= '0;
        valid_bytes_q <= '0;
        res_status_q  <= 1'b1;
        last_word_q   <= 1'b1;
      end else begin
        out_word_q    <= dig_q[{~cmd_i.out_k, 6'b000000} +: 64] & word_mask;
        word_index_q  <= cmd_i.out_k;
        valid_bytes_q <= cmd_i.out_vb;
        res_status_q  <= 1'b0;
        last_word_q   <= cmd_i.out_last;
      end
    end
  end

  assign stat_o.busy = (pend_q != 2'b00) || core_busy || core_done;
  assign stat_o.due  = (cnt_q > max_cnt_q) || (sec_q > max_sec_q);
  assign stat_o.pos  = pos[0];

  assign out_word_o    = out_word_q;
  assign word_index_o  = word_index_q;
  assign valid_bytes_o = valid_bytes_q;
  assign res_status_o  = res_status_q;
  assign last_word_o   = last_word_q;

endmodule

FILE: design/shd_ctrl.sv
module shd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           kind_i,
  input  logic                 byte_valid_i,
  input  logic                 is_entropy_i,
  input  logic                 last_byte_i,
  input  logic [5:0]           out_len_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  shd_pkg::dp_status_t  status_i,
  output shd_pkg::dp_cmd_t     cmd_o
);
  import shd_pkg::*;

  ctrl_state_e      state_q, state_d, ret_q, ret_d;
  phase_e           phase_q, phase_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [1:0]       mask_q, mask_d;
  logic             out_valid_q, out_valid_d;
  logic             olast_q, olast_d;

  kind_e       kind_q;
  logic        bv_q, ent_q, last_q;
  logic [5:0]  n_q;
  logic        item_load;

  logic [5:0]  rem;
  logic [3:0]  vb;
  logic        wlast, len_bad;

  // Output word geometry
  always_comb begin
    rem     = n_q - {1'b0, idx_q[1:0], 3'b000};
    vb      = (rem > 6'd8) ? 4'd8 : rem[3:0];
    wlast   = (rem <= 6'd8);
    len_bad = (n_q == 6'd0) || (n_q > 6'(MAX_OUT_BYTES));
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    phase_d     = phase_q;
    idx_d       = idx_q;
    mask_d      = mask_q;
    out_valid_d = out_valid_q;
    olast_d     = olast_q;
    item_load   = 1'b0;
    in_stall_o  = 1'b1;
    cmd_o       = '0;
    if (!status_i.busy) begin
      unique case (state_q)
        ST_WAIT: begin
          in_stall_o = 1'b0;
          if (in_valid_i) begin
            if (kind_e'(kind_i) == KIND_TICK) begin
              cmd_o.tick = 1'b1;
            end else begin
              item_load       = 1'b1;
              cmd_o.load_byte = 1'b1;
              state_d = (phase_q == PH_IDLE) ? ST_START : ST_BYTE;
            end
          end
        end
        ST_START: begin
          cmd_o.init = 1'b1;
          idx_d      = '0;
          unique case (kind_q)
            KIND_INST: begin
              mask_d  = MASK_DF;
              phase_d = PH_INST;
              ret_d   = ST_BYTE;
              state_d = ST_HDR;
            end
            KIND_RESEED: begin
              mask_d  = MASK_DF;
              phase_d = PH_RS_PRE;
              ret_d   = ST_ONE;
              state_d = ST_HDR;
            end
            default: begin
              if (status_i.due) begin
                mask_d  = MASK_DF;
                phase_d = PH_GD_PRE;
                ret_d   = ST_ONE;
                state_d = ST_HDR;
              end else begin
                mask_d  = MASK_H0;
                phase_d = PH_GP_NONE;
                state_d = ST_TWO;
              end
            end
          endcase
        end
        ST_HDR: begin
          cmd_o.feed = 1'b1;
          cmd_o.src  = SRC_HDR;
          cmd_o.idx  = idx_q;
          if (idx_q == IDX_W'(7)) begin
            idx_d   = '0;
            state_d = ret_q;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        ST_ONE: begin
          cmd_o.feed  = 1'b1;
          cmd_o.src   = SRC_CONST;
          cmd_o.cbyte = BYTE_RESEED;
          state_d     = ST_BYTE;
        end
        ST_TWO: begin
          cmd_o.feed  = 1'b1;
          cmd_o.src   = SRC_CONST;
          cmd_o.cbyte = BYTE_GEN;
          idx_d       = '0;
          ret_d       = ST_BYTE;
          state_d     = ST_VB;
        end
        ST_VB: begin
          cmd_o.feed = 1'b1;
          cmd_o.src  = SRC_V;
          cmd_o.idx  = idx_q;
          if (idx_q == IDX_W'(SEED_BYTES - 1)) begin
            idx_d   = '0;
            state_d = ret_q;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        ST_BYTE: begin
          state_d = ST_LAST;
          if (bv_q) begin
            unique case (phase_q) inside
              PH_RS_PRE, PH_GD_PRE: begin
                if (!ent_q) begin
                  // V goes in ahead of the first non-entropy byte
                  phase_d = (phase_q == PH_RS_PRE) ? PH_RS_POST : PH_GD_POST;
                  idx_d   = '0;
                  ret_d   = ST_INB;
                  state_d = ST_VB;
                end else begin
                  cmd_o.feed = 1'b1;
                  cmd_o.src  = SRC_IN;
                end
              end
              PH_GP_NONE, PH_GP_SEEN: begin
                if (!ent_q) begin
                  cmd_o.feed = 1'b1;
                  cmd_o.src  = SRC_IN;
                  phase_d    = PH_GP_SEEN;
                end
              end
              default: begin
                cmd_o.feed = 1'b1;
                cmd_o.src  = SRC_IN;
              end
            endcase
          end
        end
        ST_INB: begin
          cmd_o.feed = 1'b1;
          cmd_o.src  = SRC_IN;
          state_d    = ST_LAST;
        end
        ST_LAST: begin
          if (!last_q) begin
            state_d = ST_WAIT;
          end else begin
            unique case (phase_q) inside
              PH_INST, PH_RS_POST: state_d = ST_DFIN;
              PH_RS_PRE: begin
                idx_d   = '0;
                ret_d   = ST_DFIN;
                state_d = ST_VB;
              end
              PH_GD_PRE: begin
                if (len_bad) begin
                  state_d = ST_ERR;
                end else begin
                  idx_d   = '0;
                  ret_d   = ST_DFIN;
                  state_d = ST_VB;
                end
              end
              PH_GD_POST: state_d = len_bad ? ST_ERR : ST_DFIN;
              PH_GP_SEEN: begin
                if (len_bad) begin
                  state_d = ST_ERR;
                end else begin
                  ret_d   = ST_ADDT;
                  state_d = ST_PAD80;
                end
              end
              default: state_d = len_bad ? ST_ERR : ST_G1;
            endcase
          end
        end
        ST_DFIN: begin
          ret_d   = ST_STV;
          state_d = ST_PAD80;
        end
        ST_STV: begin
          // new V, then derive C from it
          cmd_o.store_v = 1'b1;
          cmd_o.init    = 1'b1;
          idx_d         = '0;
          ret_d         = ST_ZERO;
          state_d       = ST_HDR;
        end
        ST_ZERO: begin
          cmd_o.feed  = 1'b1;
          cmd_o.src   = SRC_CONST;
          cmd_o.cbyte = BYTE_DERIVE_C;
          idx_d       = '0;
          ret_d       = ST_CFIN;
          state_d     = ST_VB;
        end
        ST_CFIN: begin
          ret_d   = ST_STC;
          state_d = ST_PAD80;
        end
        ST_STC: begin
          cmd_o.store_c    = 1'b1;
          cmd_o.reseed_rst = 1'b1;
          if (phase_q == PH_GD_PRE || phase_q == PH_GD_POST) begin
            state_d = ST_G1;
          end else begin
            phase_d = PH_IDLE;
            state_d = ST_WAIT;
          end
        end
        ST_ADDT: begin
          cmd_o.add     = 1'b1;
          cmd_o.add_sel = ADD_TMP;
          state_d       = ST_G1;
        end
        ST_G1: begin
          mask_d     = MASK_H0;
          cmd_o.init = 1'b1;
          idx_d      = '0;
          ret_d      = ST_G1F;
          state_d    = ST_VB;
        end
        ST_G1F: begin
          ret_d   = ST_G1D;
          state_d = ST_PAD80;
        end
        ST_G1D: begin
          cmd_o.store_dig = 1'b1;
          cmd_o.init      = 1'b1;
          state_d         = ST_THREE;
        end
        ST_THREE: begin
          cmd_o.feed  = 1'b1;
          cmd_o.src   = SRC_CONST;
          cmd_o.cbyte = BYTE_UPDATE;
          idx_d       = '0;
          ret_d       = ST_G2F;
          state_d     = ST_VB;
        end
        ST_G2F: begin
          ret_d   = ST_ADD2;
          state_d = ST_PAD80;
        end
        ST_ADD2: begin
          cmd_o.add     = 1'b1;
          cmd_o.add_sel = ADD_TMP;
          state_d       = ST_ADDC;
        end
        ST_ADDC: begin
          cmd_o.add     = 1'b1;
          cmd_o.add_sel = ADD_C;
          state_d       = ST_ADDN;
        end
        ST_ADDN: begin
          cmd_o.add     = 1'b1;
          cmd_o.add_sel = ADD_CNT;
          cmd_o.cnt_inc = 1'b1;
          idx_d         = '0;
          state_d       = ST_OUT;
        end
        ST_OUT: begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_k    = idx_q[1:0];
          cmd_o.out_vb   = vb;
          cmd_o.out_last = wlast;
          olast_d        = wlast;
          out_valid_d    = 1'b1;
          state_d        = ST_OSEND;
        end
        ST_ERR: begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_err  = 1'b1;
          olast_d        = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_OSEND;
        end
        ST_OSEND: begin
          if (!out_stall_i) begin
            out_valid_d = 1'b0;
            if (olast_q) begin
              phase_d = PH_IDLE;
              state_d = ST_WAIT;
            end else begin
              idx_d   = idx_q + 1'b1;
              state_d = ST_OUT;
            end
          end
        end
        ST_PAD80: begin
          cmd_o.feed      = 1'b1;
          cmd_o.src       = SRC_CONST;
          cmd_o.cbyte     = BYTE_PAD;
          cmd_o.latch_len = 1'b1;
          state_d         = ST_PAD0;
        end
        ST_PAD0: begin
          if (status_i.pos == PAD_END) begin
            idx_d   = '0;
            state_d = ST_PADL;
          end else begin
            cmd_o.feed  = 1'b1;
            cmd_o.src   = SRC_CONST;
            cmd_o.cbyte = BYTE_ZERO;
          end
        end
        ST_PADL: begin
          cmd_o.feed = 1'b1;
          cmd_o.src  = SRC_LEN;
          cmd_o.idx  = idx_q;
          if (idx_q == IDX_W'(7)) begin
            idx_d   = '0;
            state_d = ret_q;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        default: state_d = ST_WAIT;
      endcase
    end
    cmd_o.mask = mask_d;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_WAIT;
      ret_q       <= ST_WAIT;
      phase_q     <= PH_IDLE;
      idx_q       <= '0;
      mask_q      <= MASK_DF;
      out_valid_q <= 1'b0;
      olast_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
      olast_q     <= olast_d;
    end
  end

  // Item control fields
  always_ff @(posedge clk_i) begin
    if (item_load) begin
      kind_q <= kind_e'(kind_i);
      bv_q   <= byte_valid_i;
      ent_q  <= is_entropy_i;
      last_q <= last_byte_i;
      n_q    <= out_len_i;
    end
  end

  assign out_valid_o = out_valid_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !status_i.busy)
    else $error("input transfer while datapath busy");

  a_cmd_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.feed || cmd_o.init || cmd_o.add || cmd_o.store_v) |-> !status_i.busy)
    else $error("datapath command issued during compression");

  a_out_in_gen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (phase_q == PH_GD_PRE || phase_q == PH_GD_POST ||
                     phase_q == PH_GP_NONE || phase_q == PH_GP_SEEN))
    else $error("result outside a generate");

  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> in_stall_o)
    else $error("input open while a result is pending");

endmodule

FILE: design/sm3_hash_drbg.sv
// Items are taken one at a time; every 64th byte fed to the derivation adds two SM3
// compressions on the one shared round unit. Instantiate/reseed finish runs 6 to 8
// compressions plus a 64-byte feed to derive C; generate finish runs 3 to 5, plus
// 6 to 8 when a reseed is due, then emits its words one at a time, each held while
// the output stalls. Reset (async, active low) zeroes V, C and counters, restores
// limits.
module sm3_hash_drbg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     kind_i,
  input  logic [7:0]                     data_byte_i,
  input  logic                           byte_valid_i,
  input  logic                           is_entropy_i,
  input  logic                           last_byte_i,
  input  logic [5:0]                     out_len_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [63:0]                    out_word_o,
  output logic [1:0]                     word_index_o,
  output logic [3:0]                     valid_bytes_o,
  output logic                           status_o,
  output logic                           last_word_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [shd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]                    cfg_data_i
);
  import shd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t stat;

  // Limits are plain registers, always writable
  assign cfg_ready_o = 1'b1;

  shd_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .byte_valid_i (byte_valid_i),
    .is_entropy_i (is_entropy_i),
    .last_byte_i  (last_byte_i),
    .out_len_i    (out_len_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_i     (stat),
    .cmd_o        (cmd)
  );

  shd_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .data_byte_i   (data_byte_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_word_o    (out_word_o),
    .word_index_o  (word_index_o),
    .valid_bytes_o (valid_bytes_o),
    .res_status_o  (status_o),
    .last_word_o   (last_word_o)
  );

endmodule

FILE: dv/sm3_hash_drbg_tb.sv
module sm3_hash_drbg_tb;
  import shd_pkg::*;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       bv;
    logic       ent;
    logic       last;
    logic [5:0] len;
  } drbg_item_t;

  typedef struct packed {
    logic [63:0] word;
    logic [1:0]  idx;
    logic [3:0]  vb;
    logic        st;
    logic        lw;
  } drbg_word_t;

  // Predicts the generator and checks its output words in order
  class drbg_scoreboard;
    bit [439:0]  seed_v, seed_c;
    bit [31:0]   rs_count, secs, lim_count, lim_secs;
    bit [31:0]   chain [2][8];
    bit [7:0]    blk [2][64];
    bit [63:0]   mlen [2];
    phase_e      phase;
    drbg_word_t  words_q [$];
    int          errors;

    function new();
      lim_count = 32'd1048576;
      lim_secs  = 32'd600;
      seed_v = '0;
      seed_c = '0;
      rs_count = 0;
      secs = 0;
      phase = PH_IDLE;
      errors = 0;
      h_init(0);
      h_init(1);
    endfunction

    function void set_limit(logic [CFG_IDX_W-1:0] idx, bit [31:0] val);
      if (idx == CFG_MAX_COUNT) lim_count = val;
      else if (idx == CFG_MAX_SECONDS) lim_secs = val;
    endfunction

    function bit [31:0] rol(bit [31:0] x, int n);
      n = n % 32;
      if (n == 0) return x;
      return (x << n) | (x >> (32 - n));
    endfunction

    function void compress(int k);
      bit [31:0] w [68];
      bit [31:0] a, b, c, d, e, f, g, h, t, ss1, ss2, ff, gg, tt1, tt2, x;
      for (int j = 0; j < 16; j++)
        w[j] = {blk[k][4*j], blk[k][4*j+1], blk[k][4*j+2], blk[k][4*j+3]};
      for (int j = 16; j < 68; j++) begin
        x = w[j-16] ^ w[j-9] ^ rol(w[j-3], 15);
        w[j] = (x ^ rol(x, 15) ^ rol(x, 23)) ^ rol(w[j-13], 7) ^ w[j-6];
      end
      a = chain[k][0]; b = chain[k][1]; c = chain[k][2]; d = chain[k][3];
      e = chain[k][4]; f = chain[k][5]; g = chain[k][6]; h = chain[k][7];
      for (int j = 0; j < 64; j++) begin
        t = (j < 16) ? SM3_T_LO : SM3_T_HI;
        ss1 = rol(rol(a, 12) + e + rol(t, j), 7);
        ss2 = ss1 ^ rol(a, 12);
        ff = (j < 16) ? (a ^ b ^ c) : ((a & b) | (a & c) | (b & c));
        gg = (j < 16) ? (e ^ f ^ g) : ((e & f) | (~e & g));
        tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
        tt2 = gg + h + ss1 + w[j];
        d = c; c = rol(b, 9); b = a; a = tt1;
        h = g; g = rol(f, 19); f = e;
        e = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
      end
      chain[k][0] ^= a; chain[k][1] ^= b; chain[k][2] ^= c; chain[k][3] ^= d;
      chain[k][4] ^= e; chain[k][5] ^= f; chain[k][6] ^= g; chain[k][7] ^= h;
    endfunction

    function void h_init(int k);
      for (int i = 0; i < 8; i++) chain[k][i] = SM3_IV[255-32*i -: 32];
      for (int i = 0; i < 64; i++) blk[k][i] = 0;
      mlen[k] = 0;
    endfunction

    function void h_byte(int k, bit [7:0] v);
      int pos;
      pos = mlen[k][5:0];
      blk[k][pos] = v;
      mlen[k]++;
      if (pos == 63) compress(k);
    endfunction

    function void h_seed(int k);
      for (int i = 0; i < 55; i++) h_byte(k, seed_v[439-8*i -: 8]);
    endfunction

    function bit [255:0] h_final(int k);
      bit [63:0]  bits;
      bit [255:0] d;
      bits = mlen[k] << 3;
      h_byte(k, BYTE_PAD);
      while (mlen[k][5:0] != PAD_END) h_byte(k, BYTE_ZERO);
      for (int i = 7; i >= 0; i--) h_byte(k, bits[8*i +: 8]);
      for (int i = 0; i < 8; i++) d[255-32*i -: 32] = chain[k][i];
      return d;
    endfunction

    function void df_byte(bit [7:0] v);
      h_byte(0, v);
      h_byte(1, v);
    endfunction

    function void df_seed();
      h_seed(0);
      h_seed(1);
    endfunction

    // Derivation header: counter, then the 440-bit output length
    function void df_start();
      h_init(0);
      h_init(1);
      for (int k = 0; k < 2; k++)
        for (int i = 0; i < 8; i++)
          h_byte(k, 8'((i == 3) ? k + 1 : (i == 6) ? SEED_BITS / 256 :
                       (i == 7) ? SEED_BITS % 256 : 0));
    endfunction

    function bit [439:0] df_finish();
      bit [255:0] d0, d1;
      d0 = h_final(0);
      d1 = h_final(1);
      return {d0, d1[255:72]};
    endfunction

    function void reseed_done();
      seed_v = df_finish();
      df_start();
      df_byte(BYTE_DERIVE_C);
      df_seed();
      seed_c = df_finish();
      rs_count = 1;
      secs = 0;
    endfunction

    function void note(drbg_item_t it);
      phase_e     ph;
      bit [255:0] dig, tmp;
      int         vb;
      drbg_word_t r;
      if (it.kind == KIND_TICK) begin
        if (secs != 32'hffffffff) secs++;
        return;
      end
      if (phase == PH_IDLE) begin
        if (it.kind == KIND_INST) begin
          df_start();
          phase = PH_INST;
        end else if (it.kind == KIND_RESEED) begin
          df_start();
          df_byte(BYTE_RESEED);
          phase = PH_RS_PRE;
        end else if (rs_count > lim_count || secs > lim_secs) begin
          df_start();
          df_byte(BYTE_RESEED);
          phase = PH_GD_PRE;
        end else begin
          h_init(0);
          h_byte(0, BYTE_GEN);
          h_seed(0);
          phase = PH_GP_NONE;
        end
      end
      ph = phase;
      if (it.bv) begin
        if (ph == PH_INST || ph == PH_RS_POST || ph == PH_GD_POST) begin
          df_byte(it.data);
        end else if (ph == PH_RS_PRE || ph == PH_GD_PRE) begin
          if (!it.ent) begin
            df_seed();
            phase = (ph == PH_RS_PRE) ? PH_RS_POST : PH_GD_POST;
          end
          df_byte(it.data);
        end else if (!it.ent) begin
          h_byte(0, it.data);
          phase = PH_GP_SEEN;
        end
      end
      if (!it.last) return;
      ph = phase;
      phase = PH_IDLE;
      if (ph == PH_INST) begin
        reseed_done();
        return;
      end
      if (ph == PH_RS_PRE || ph == PH_RS_POST) begin
        if (ph == PH_RS_PRE) df_seed();
        reseed_done();
        return;
      end
      // Bad length: single error word, state untouched
      if (it.len < 1 || it.len > MAX_OUT_BYTES) begin
        r = '{word: '0, idx: '0, vb: '0, st: 1'b1, lw: 1'b1};
        words_q.push_back(r);
        return;
      end
      if (ph == PH_GD_PRE) df_seed();
      if (ph == PH_GD_PRE || ph == PH_GD_POST) reseed_done();
      if (ph == PH_GP_SEEN) seed_v = seed_v + h_final(0);
      h_init(0);
      h_seed(0);
      dig = h_final(0);
      h_init(0);
      h_byte(0, BYTE_UPDATE);
      h_seed(0);
      tmp = h_final(0);
      seed_v = seed_v + tmp + seed_c + rs_count;
      rs_count++;
      for (int k = 0; k * 8 < it.len; k++) begin
        vb = it.len - k * 8;
        if (vb > 8) vb = 8;
        r.word = '0;
        for (int i = 0; i < 8; i++)
          r.word = (r.word << 8) | ((i < vb) ? dig[255-8*(k*8+i) -: 8] : 8'h00);
        r.idx = 2'(k);
        r.vb = 4'(vb);
        r.st = 1'b0;
        r.lw = ((k + 1) * 8 >= it.len);
        words_q.push_back(r);
      end
    endfunction

    function void check(drbg_word_t got);
      drbg_word_t exp;
      if (words_q.size() == 0) begin
        $display("%0t: unexpected output word %h", $time, got.word);
        errors++;
        return;
      end
      exp = words_q.pop_front();
      if (got.word !== exp.word) begin
        $display("%0t: out_word exp %h got %h", $time, exp.word, got.word);
        errors++;
      end
      if (got.idx !== exp.idx) begin
        $display("%0t: word_index exp %0d got %0d", $time, exp.idx, got.idx);
        errors++;
      end
      if (got.vb !== exp.vb) begin
        $display("%0t: valid_bytes exp %0d got %0d", $time, exp.vb, got.vb);
        errors++;
      end
      if (got.st !== exp.st) begin
        $display("%0t: status exp %0d got %0d", $time, exp.st, got.st);
        errors++;
      end
      if (got.lw !== exp.lw) begin
        $display("%0t: last_word exp %0d got %0d", $time, exp.lw, got.lw);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  drbg_item_t           in_item = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [63:0]          out_word;
  logic [1:0]           word_index;
  logic [3:0]           valid_bytes;
  logic                 status;
  logic                 last_word;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  drbg_scoreboard sb = new();
  bit             quiet = 1'b0;
  int             items_sent = 0;

  sm3_hash_drbg dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .kind_i       (in_item.kind),
    .data_byte_i  (in_item.data),
    .byte_valid_i (in_item.bv),
    .is_entropy_i (in_item.ent),
    .last_byte_i  (in_item.last),
    .out_len_i    (in_item.len),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_word_o   (out_word),
    .word_index_o (word_index),
    .valid_bytes_o(valid_bytes),
    .status_o     (status),
    .last_word_o  (last_word),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  // Hard stop
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  // Output side: random stall, check each transfer
  initial begin
    int         stall_left;
    bit         acc;
    drbg_word_t got;
    stall_left = 0;
    forever begin
      @(negedge clk);
      acc = out_valid && !out_stall;
      got = '{word: out_word, idx: word_index, vb: valid_bytes, st: status, lw: last_word};
      @(posedge clk);
      if (acc) begin
        sb.check(got);
        stall_left = quiet ? 0 : $urandom_range(0, 9);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // One input transfer; valid stays high for a back-to-back item
  task automatic send_item(drbg_item_t it);
    int gap;
    bit acc;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do begin
      @(negedge clk);
      acc = !in_stall;
      @(posedge clk);
    end while (!acc);
    sb.note(it);
    items_sent++;
  endtask

  task automatic send(kind_e k, bit [7:0] d, bit bv, bit ent, bit last, bit [5:0] len);
    drbg_item_t it;
    it = '{kind: k, data: d, bv: bv, ent: ent, last: last, len: len};
    send_item(it);
  endtask

  // Tick with random filler in the unused fields
  task automatic send_tick();
    send(KIND_TICK, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
         6'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.words_q.size() > 0);
    repeat (3000) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, bit [31:0] val);
    bit acc;
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      acc = cfg_ready;
      @(posedge clk);
    end while (!acc);
    cfg_valid <= 1'b0;
    sb.set_limit(idx, val);
  endtask

  // Random operation: mostly well-formed, with stray ticks and odd lengths
  task automatic rand_op();
    kind_e      k;
    int         n, sel;
    drbg_item_t it;
    sel = $urandom_range(0, 99);
    k = (sel < 15) ? KIND_INST : (sel < 35) ? KIND_RESEED : (sel < 92) ? KIND_GEN : KIND_TICK;
    if (k == KIND_TICK) begin
      repeat ($urandom_range(1, 4)) send_tick();
      return;
    end
    n = ($urandom_range(0, 14) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 6);
    for (int i = 0; i < ((n == 0) ? 1 : n); i++) begin
      if ($urandom_range(0, 9) == 0)
        send_tick();
      it.kind = (i == 0) ? k : kind_e'($urandom_range(0, 2));
      it.data = 8'($urandom);
      it.bv = (n != 0) && ($urandom_range(0, 9) != 0);
      it.ent = 1'($urandom);
      it.last = (i == ((n == 0) ? 0 : n - 1));
      if ($urandom_range(0, 7) == 0)
        it.len = $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(33, 63));
      else it.len = 6'($urandom_range(1, 32));
      send_item(it);
    end
  endtask

  task automatic rand_phase(int count);
    int stop;
    stop = items_sent + count;
    while (items_sent < stop) begin
      if ($urandom_range(0, 19) == 0) quiet = !quiet;
      rand_op();
    end
    quiet = 1'b0;
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: instantiate with an empty item and byte extremes
    send(KIND_INST, 8'h00, 1'b1, 1'b1, 1'b0, 6'd0);
    send(KIND_GEN, 8'hff, 1'b1, 1'b0, 1'b0, 6'd63);
    send(KIND_INST, 8'h5a, 1'b0, 1'b0, 1'b1, 6'd0);
    // Generate: full length with additional input, then short and bad lengths
    send(KIND_GEN, 8'ha5, 1'b1, 1'b0, 1'b1, 6'd32);
    send(KIND_GEN, 8'h00, 1'b0, 1'b0, 1'b1, 6'd1);
    send(KIND_GEN, 8'h11, 1'b1, 1'b1, 1'b1, 6'd0);
    send(KIND_GEN, 8'h22, 1'b1, 1'b0, 1'b1, 6'd33);
    send(KIND_GEN, 8'h33, 1'b1, 1'b0, 1'b1, 6'd63);
    // Not due: entropy ignored, additional input seen
    send(KIND_GEN, 8'h44, 1'b1, 1'b1, 1'b0, 6'd0);
    send(KIND_RESEED, 8'h55, 1'b1, 1'b0, 1'b1, 6'd8);
    // Reseed: entropy, additional input, entropy after it
    send(KIND_RESEED, 8'hf0, 1'b1, 1'b1, 1'b0, 6'd0);
    send(KIND_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0);
    send(KIND_INST, 8'h0f, 1'b1, 1'b0, 1'b0, 6'd0);
    send(KIND_GEN, 8'h99, 1'b1, 1'b1, 1'b1, 6'd0);
    // Reseed with entropy only: V goes in at the finish
    send(KIND_RESEED, 8'h7e, 1'b1, 1'b1, 1'b1, 6'd0);
    send(KIND_GEN, 8'h00, 1'b0, 1'b0, 1'b1, 6'd9);
    drain();

    // Forced reseed by count
    write_cfg(CFG_MAX_COUNT, 32'd1);
    write_cfg(CFG_MAX_SECONDS, 32'hffffffff);
    send(KIND_GEN, 8'hc3, 1'b1, 1'b1, 1'b0, 6'd0);
    send(KIND_GEN, 8'h3c, 1'b1, 1'b0, 1'b1, 6'd16);
    send(KIND_GEN, 8'h81, 1'b1, 1'b1, 1'b1, 6'd24);
    drain();
    rand_phase(64);

    // Forced reseed by elapsed seconds
    write_cfg(CFG_MAX_COUNT, 32'hffffffff);
    write_cfg(CFG_MAX_SECONDS, 32'd1);
    rand_phase(64);

    write_cfg(CFG_MAX_COUNT, 32'd3);
    write_cfg(CFG_MAX_SECONDS, 32'd5);
    rand_phase(64);

    if (sb.errors == 0 && sb.words_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
